FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh: concurrent assertion shorthands
// Each macro expands to one labeled property with a disable-iff reset guard.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pwsm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwsm_pkg: shared types and constants of the wheel and pedal servo mapper
// Item structs, controller command and status, fixed arithmetic constants.
// ---------------------------------------------------------------------------
package pwsm_pkg;

  localparam int AXIS_W  = 16;
  localparam int BRAKE_W = 15;
  localparam int THR_W   = 8;
  localparam int STEER_W = 7;
  localparam int GEAR_W  = 4;
  localparam int ENTRY_W = 17;
  localparam int MUL_W   = 28;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ADD_W   = 16;
  localparam int U_W     = 27;
  localparam int W_W     = 16;
  localparam int GPOS_W  = 17;

  // Hat and brake strength
  localparam logic [AXIS_W-1:0]  HAT_UP_END  = 16'd100;
  localparam logic [AXIS_W-1:0]  HAT_DOWN_LO = 16'd18000;
  localparam logic [AXIS_W-1:0]  HAT_DOWN_HI = 16'd18100;
  localparam logic [BRAKE_W-1:0] BRAKE_STEP  = 15'd250;
  localparam logic [BRAKE_W-1:0] BRAKE_MAX   = 15'd20000;

  // Gear range and power limits
  localparam logic signed [GEAR_W-1:0] GEAR_REV = -4'sd1;
  localparam logic signed [GEAR_W-1:0] GEAR_TOP = 4'sd5;
  localparam logic [GPOS_W-1:0] REV_LIMIT   = 17'd16383;
  localparam logic [AXIS_W-1:0] LIMIT_GEAR1 = 16'd13107;
  localparam logic [AXIS_W-1:0] LIMIT_GEAR2 = 16'd14417;
  localparam logic [AXIS_W-1:0] LIMIT_GEAR3 = 16'd16383;
  localparam logic [AXIS_W-1:0] LIMIT_GEAR4 = 16'd19660;
  localparam logic [AXIS_W-1:0] LIMIT_GEAR5 = 16'd65535;

  // Rounding addends
  localparam logic [ADD_W-1:0] IDX_ROUND   = 16'd32767;
  localparam logic [ADD_W-1:0] BRAKE_ROUND = 16'd32768;

  // Throttle mapping
  localparam logic [GPOS_W-1:0] THR_OFFSET = 17'h10000;
  localparam logic [MUL_W-1:0]  THR_SCALE  = 28'd180;

  // Steering mapping: divide by 23536 as a shift by 4 and a divide by 1471,
  // the latter as a multiply by floor(2^38 / 1471) plus one correction.
  localparam logic [AXIS_W-1:0]  STEER_LO    = 16'd21000;
  localparam logic [AXIS_W-1:0]  STEER_HI    = 16'd44536;
  localparam logic [MUL_W-1:0]   STEER_RECIP = 28'd186864654;
  localparam int                 STEER_Q_LSB = 38;
  localparam logic [MUL_W-1:0]   STEER_DIV   = 28'd1471;
  localparam logic [MUL_W-1:0]   STEER_SCALE = 28'd56;
  localparam logic [W_W-1:0]     STEER_BASE  = 16'd70;
  localparam logic [STEER_W-1:0] STEER_MIN   = 7'd70;
  localparam logic [STEER_W-1:0] STEER_MAX   = 7'd126;
  localparam logic [THR_W-1:0]   THR_MAX     = 8'd180;

  typedef struct packed {
    logic [AXIS_W-1:0] wheel_pos;
    logic [AXIS_W-1:0] gas_pedal;
    logic [AXIS_W-1:0] brake_pedal;
    logic              hat_centered;
    logic [AXIS_W-1:0] hat_angle;
    logic              shift_down;
    logic              shift_up;
    logic              handbrake;
  } sample_t;

  typedef struct packed {
    logic [THR_W-1:0]          throttle_pulse;
    logic [STEER_W-1:0]        steering_pulse;
    logic signed [GEAR_W-1:0]  gear_now;
    logic [BRAKE_W-1:0]        brake_level;
  } servo_t;

  // Operand selection of the shared multiply-add unit
  typedef enum logic [2:0] {
    MUL_HOLD,
    MUL_IDX,
    MUL_STEER,
    MUL_REM,
    MUL_BRAKE,
    MUL_WSCALE,
    MUL_THR
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    steer_en;
    logic    idx_en;
    logic    rom_en;
    logic    w_en;
    logic    g_en;
    logic    pulse_en;
    logic    out_wr;
    mul_op_t mul_op;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } status_t;

endpackage

FILE: design/pedal_wheel_to_servo_mapper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pedal_wheel_to_servo_mapper: wheel, pedals, hat and paddles to servo values
// Input channel sample_valid/sample_ready/sample carries one controller item;
// output channel servo_valid/servo_ready/servo carries one servo item back.
// Every accepted item gives exactly one result item, in order.
// One item is in flight at a time: the next is taken only after the result is
// written; the shared multiply-add unit is used in six consecutive steps of
// the sequencer, and the curve ROM read is registered.
// The block takes the next item while a finished result waits in the output
// register; if servo_ready stays low, the sequencer holds in its last step
// until that register frees, and then sample_ready rises again.
// Reset (rst, synchronous): gear neutral, paddle and hat history cleared,
// brake strength to BRAKE_START, no result pending. The curve ROM is constant
// and needs no fill after reset.
// CURVE_ENTRIES sets the depth of the brake curve ROM.
// ---------------------------------------------------------------------------
module pedal_wheel_to_servo_mapper #(
  parameter int unsigned BRAKE_START   = 5000,
  parameter int unsigned CURVE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  pwsm_pkg::sample_t  sample,
  output logic               servo_valid,
  input  logic               servo_ready,
  output pwsm_pkg::servo_t   servo
);
  import pwsm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: one item at a time, one step per cycle while the output is not stalled
  pwsm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: sample state, curve ROM, multiply-add unit, output register
  pwsm_datapath #(
    .BRAKE_START   (BRAKE_START),
    .CURVE_ENTRIES (CURVE_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample      (sample),
    .servo       (servo),
    .servo_valid (servo_valid),
    .servo_ready (servo_ready)
  );

endmodule

FILE: design/pwsm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwsm_ctrl: sequencer of the servo mapper
// Walks one item through the datapath steps and drives the input handshake.
// ---------------------------------------------------------------------------
module pwsm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  pwsm_pkg::status_t  status,
  output pwsm_pkg::cmd_t     cmd
);
  import pwsm_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_IDX_MUL   = 8'b0000_0010,
    ST_IDX_DIV   = 8'b0000_0100,
    ST_ROM_RD    = 8'b0000_1000,
    ST_STEER_FIX = 8'b0001_0000,
    ST_BRAKE     = 8'b0010_0000,
    ST_STEER_OUT = 8'b0100_0000,
    ST_THR_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    cmd          = '0;
    cmd.mul_op   = MUL_HOLD;
    case (state)
      ST_IDLE: begin
        // take no item while in reset
        sample_ready = !rst;
        if (sample_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_IDX_MUL;
        end
      end
      ST_IDX_MUL: begin
        cmd.steer_en = 1'b1;
        cmd.mul_op   = MUL_IDX;
        state_next   = ST_IDX_DIV;
      end
      ST_IDX_DIV: begin
        cmd.idx_en = 1'b1;
        cmd.mul_op = MUL_STEER;
        state_next = ST_ROM_RD;
      end
      ST_ROM_RD: begin
        cmd.rom_en = 1'b1;
        cmd.mul_op = MUL_REM;
        state_next = ST_STEER_FIX;
      end
      ST_STEER_FIX: begin
        cmd.w_en   = 1'b1;
        cmd.mul_op = MUL_BRAKE;
        state_next = ST_BRAKE;
      end
      ST_BRAKE: begin
        cmd.g_en   = 1'b1;
        cmd.mul_op = MUL_WSCALE;
        state_next = ST_STEER_OUT;
      end
      ST_STEER_OUT: begin
        cmd.pulse_en = 1'b1;
        cmd.mul_op   = MUL_THR;
        state_next   = ST_THR_OUT;
      end
      ST_THR_OUT: begin
        // hold here until the output register is free
        if (!status.out_stall) begin
          cmd.out_wr = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/pwsm_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwsm_datapath: registers, brake curve ROM and shared multiply-add unit
// Holds sample state (hat, paddles, gear, brake strength) and the output item.
// ---------------------------------------------------------------------------
module pwsm_datapath #(
  parameter int unsigned BRAKE_START   = 5000,
  parameter int unsigned CURVE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  pwsm_pkg::cmd_t     cmd,
  output pwsm_pkg::status_t  status,
  input  pwsm_pkg::sample_t  sample,
  output pwsm_pkg::servo_t   servo,
  output logic               servo_valid,
  input  logic               servo_ready
);
  import pwsm_pkg::*;

  localparam int unsigned IDX_W    = $clog2(CURVE_ENTRIES);
  localparam int unsigned NM1      = CURVE_ENTRIES - 1;
  localparam int unsigned NM1_HALF = NM1 / 2;
  localparam logic [63:0] CURVE_C_Q40 = 64'd77268020;
  localparam logic [63:0] ONE_Q40     = 64'd1 << 40;

  // Elaboration-time Q40 arithmetic for the curve table
  function automatic logic [63:0] q40_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah  = a >> 20;
    al  = a & 64'h000F_FFFF;
    bh  = b >> 20;
    bl  = b & 64'h000F_FFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 20);
    return ah * bh + (mid >> 20);
  endfunction

  // Restoring long division, used only while building the curve table
  function automatic logic [63:0] div_q64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [ENTRY_W-1:0] curve_entry(input int unsigned i);
    logic [63:0] x, t, sum, term, ent;
    x    = div_q64(64'(i) * 64'd65535 + 64'(NM1_HALF), 64'(NM1));
    t    = CURVE_C_Q40 * x;
    sum  = ONE_Q40;
    term = ONE_Q40;
    for (int k = 1; k <= 40; k++) begin
      term = div_q64(q40_mul(term, t), 64'(k));
      sum  = sum + term;
    end
    ent = div_q64(sum + (64'd50 << 24), 64'd100 << 24);
    return ENTRY_W'(ent);
  endfunction

  // Divide by 65535 for values below 2^32 - 65536: one correction step
  function automatic logic [15:0] div_65535(input logic [31:0] v);
    logic [15:0] q0;
    logic [16:0] r0;
    q0 = v[31:16];
    r0 = {1'b0, v[15:0]} + {1'b0, q0};
    return q0 + {15'd0, (r0 >= 17'd65535)};
  endfunction

  // Divide by 131071 for products of a 17-bit value and 180
  function automatic logic [THR_W-1:0] div_131071(input logic [24:0] v);
    logic [7:0]  q0;
    logic [17:0] r0;
    q0 = v[24:17];
    r0 = {1'b0, v[16:0]} + {10'd0, q0};
    return q0 + {7'd0, (r0 >= 18'd131071)};
  endfunction

  // Brake curve ROM
  logic [ENTRY_W-1:0] curve_rom [CURVE_ENTRIES];

  for (genvar gi = 0; gi < CURVE_ENTRIES; gi++) begin : g_rom
    localparam logic [ENTRY_W-1:0] ENTRY = curve_entry(gi);
    assign curve_rom[gi] = ENTRY;
  end

  // State and working registers
  sample_t                  smp;
  logic signed [GEAR_W-1:0] gear;
  logic                     down_prev;
  logic                     up_prev;
  logic                     hat_held;
  logic [BRAKE_W-1:0]       brake_strength;

  logic [U_W-1:0]           steer_u;
  logic [IDX_W-1:0]         idx;
  logic [ENTRY_W-1:0]       rom_q;
  logic [W_W-1:0]           qest;
  logic [W_W-1:0]           w;
  logic [GPOS_W-1:0]        gpos;
  logic [STEER_W-1:0]       steer_pulse;
  logic [PROD_W-1:0]        prod;

  // Next values on accept
  logic                     hat_held_next;
  logic [BRAKE_W-1:0]       strength_next;
  logic [BRAKE_W-1:0]       strength_up;
  logic signed [GEAR_W-1:0] gear_mid;
  logic signed [GEAR_W-1:0] gear_next;

  always_comb begin
    hat_held_next = hat_held;
    strength_next = brake_strength;
    strength_up   = brake_strength + BRAKE_STEP;
    if (!sample.hat_centered && !hat_held) begin
      hat_held_next = 1'b1;
      if (sample.hat_angle < HAT_UP_END) begin
        strength_next = (strength_up > BRAKE_MAX) ? BRAKE_MAX : strength_up;
      end else if (sample.hat_angle >= HAT_DOWN_LO && sample.hat_angle < HAT_DOWN_HI) begin
        strength_next = (brake_strength >= BRAKE_STEP) ? brake_strength - BRAKE_STEP : '0;
      end
    end
    if (sample.hat_centered) begin
      hat_held_next = 1'b0;
    end

    // downshift first, then upshift, each within reverse..top
    gear_mid = gear;
    if (sample.shift_down && !down_prev && gear != GEAR_REV) begin
      gear_mid = gear - 4'sd1;
    end
    gear_next = gear_mid;
    if (sample.shift_up && !up_prev && gear_mid != GEAR_TOP) begin
      gear_next = gear_mid + 4'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gear           <= '0;
      down_prev      <= 1'b0;
      up_prev        <= 1'b0;
      hat_held       <= 1'b0;
      brake_strength <= BRAKE_W'(BRAKE_START);
    end else if (cmd.load) begin
      gear           <= gear_next;
      down_prev      <= sample.shift_down;
      up_prev        <= sample.shift_up;
      hat_held       <= hat_held_next;
      brake_strength <= strength_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= sample;
    end
  end

  // Steering offset scaled by 65535 / 16
  logic [AXIS_W-1:0]  s_clamp;
  logic [BRAKE_W-1:0] s_off;
  logic [30:0]        s_scaled;

  always_comb begin
    if (smp.wheel_pos > STEER_HI) begin
      s_clamp = STEER_HI;
    end else if (smp.wheel_pos < STEER_LO) begin
      s_clamp = STEER_LO;
    end else begin
      s_clamp = smp.wheel_pos;
    end
    s_off    = BRAKE_W'(s_clamp - STEER_LO);
    s_scaled = {s_off, 16'd0} - {16'd0, s_off};
  end

  // Shared multiply-add unit
  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;
  logic [ADD_W-1:0] mul_c;
  logic [AXIS_W-1:0] rb;

  assign rb = ~smp.brake_pedal;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    case (cmd.mul_op)
      MUL_IDX: begin
        mul_a = MUL_W'(rb);
        mul_b = MUL_W'(NM1);
        mul_c = IDX_ROUND;
      end
      MUL_STEER: begin
        mul_a = MUL_W'(steer_u);
        mul_b = STEER_RECIP;
      end
      MUL_REM: begin
        mul_a = MUL_W'(prod[STEER_Q_LSB +: W_W]);
        mul_b = STEER_DIV;
      end
      MUL_BRAKE: begin
        mul_a = MUL_W'(rom_q);
        mul_b = MUL_W'(brake_strength);
        mul_c = BRAKE_ROUND;
      end
      MUL_WSCALE: begin
        mul_a = MUL_W'(w);
        mul_b = STEER_SCALE;
      end
      MUL_THR: begin
        mul_a = MUL_W'(gpos);
        mul_b = THR_SCALE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_HOLD) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b) + PROD_W'(mul_c);
    end
  end

  // Gas minus brake, clamped to the gear's limit (reverse: plus brake), offset
  logic [AXIS_W-1:0]        brake_val;
  logic [AXIS_W-1:0]        rg;
  logic [17:0]              rev_sum;
  logic signed [17:0]       fwd_diff;
  logic [AXIS_W-1:0]        fwd_limit;
  logic [GPOS_W-1:0]        gpos_next;
  logic [U_W-1:0]           steer_rem;

  always_comb begin
    case (gear)
      4'sd1:   fwd_limit = LIMIT_GEAR1;
      4'sd2:   fwd_limit = LIMIT_GEAR2;
      4'sd3:   fwd_limit = LIMIT_GEAR3;
      4'sd4:   fwd_limit = LIMIT_GEAR4;
      4'sd5:   fwd_limit = LIMIT_GEAR5;
      default: fwd_limit = '0;
    endcase
  end

  always_comb begin
    brake_val = (smp.brake_pedal == '1) ? '0 : prod[31:16];
    rg        = ~smp.gas_pedal;
    rev_sum   = {2'b00, rg} + {2'b00, brake_val};
    fwd_diff  = $signed({2'b00, rg}) - $signed({2'b00, brake_val});
    if (smp.handbrake) begin
      gpos_next = THR_OFFSET;
    end else if (gear == GEAR_REV) begin
      if (rev_sum > {1'b0, REV_LIMIT}) begin
        gpos_next = THR_OFFSET - REV_LIMIT;
      end else begin
        gpos_next = THR_OFFSET - rev_sum[GPOS_W-1:0];
      end
    end else if (fwd_diff < 0) begin
      gpos_next = THR_OFFSET;
    end else if (fwd_diff > $signed({2'b00, fwd_limit})) begin
      gpos_next = THR_OFFSET + {1'b0, fwd_limit};
    end else begin
      gpos_next = THR_OFFSET + fwd_diff[GPOS_W-1:0];
    end
  end

  assign steer_rem = steer_u - prod[U_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.steer_en) begin
      steer_u <= s_scaled[30:4];
    end
    if (cmd.idx_en) begin
      idx <= IDX_W'(div_65535(prod[31:0]));
    end
    if (cmd.rom_en) begin
      rom_q <= curve_rom[idx];
      qest  <= prod[STEER_Q_LSB +: W_W];
    end
    if (cmd.w_en) begin
      w <= qest + {15'd0, (steer_rem >= U_W'(STEER_DIV))};
    end
    if (cmd.g_en) begin
      gpos <= gpos_next;
    end
    if (cmd.pulse_en) begin
      steer_pulse <= STEER_W'(div_65535(prod[31:0]) + STEER_BASE);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      servo_valid <= 1'b0;
    end else if (cmd.out_wr) begin
      servo_valid <= 1'b1;
    end else if (servo_ready) begin
      servo_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_wr) begin
      servo.throttle_pulse <= div_131071(prod[24:0]);
      servo.steering_pulse <= steer_pulse;
      servo.gear_now       <= gear;
      servo.brake_level    <= brake_strength;
    end
  end

  assign status.out_stall = servo_valid && !servo_ready;

endmodule

FILE: design/pwsm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwsm_checker: port-level checks of the servo mapper
// Watches the handshakes and result ranges; bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pwsm_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input logic              servo_valid,
  input logic              servo_ready,
  input pwsm_pkg::servo_t  servo
);
  import pwsm_pkg::*;

  // A stalled result holds
  `ASSERT_NEXT(a_servo_hold, clk, rst, servo_valid && !servo_ready, servo_valid && $stable(servo), "servo item changed while stalled")

  // Results stay within the servo and gear ranges
  `ASSERT_IMPLIES(a_servo_range, clk, rst, servo_valid, servo.throttle_pulse <= THR_MAX && servo.steering_pulse >= STEER_MIN && servo.steering_pulse <= STEER_MAX && $signed(servo.gear_now) >= GEAR_REV && $signed(servo.gear_now) <= GEAR_TOP && servo.brake_level <= BRAKE_MAX, "servo item out of range")

  // One item at a time: no second accept right after an accept
  `ASSERT_NEXT(a_one_item, clk, rst, sample_valid && sample_ready, !sample_ready, "sample accepted while busy")

endmodule

bind pedal_wheel_to_servo_mapper pwsm_checker u_pwsm_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .servo_valid  (servo_valid),
  .servo_ready  (servo_ready),
  .servo        (servo)
);
